/* rtl/trd_pkg.sv */
// trd_pkg: shared types and constants of the timing string run decoder
// used by the output channel interface trd_out_if and by timing_string_run_decoder
`default_nettype none

package trd_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ColW    = 33;
  localparam int unsigned AddrW   = 40;
  localparam int unsigned IdxW    = 3;

  // header and pair field sizes
  localparam logic [IdxW-1:0] TotalLastIdx = 3'd7;
  localparam logic [IdxW-1:0] WordLastIdx  = 3'd3;
  localparam logic [7:0]      ValSize1     = 8'd1;
  localparam logic [7:0]      ValSize2     = 8'd2;
  localparam logic [7:0]      ValSize4     = 8'd4;
  localparam logic [7:0]      RepSize4     = 8'd4;

  typedef enum logic [8:0] {
    PH_TOTAL = 9'b000000001,
    PH_NCHAN = 9'b000000010,
    PH_VSIZE = 9'b000000100,
    PH_RSIZE = 9'b000001000,
    PH_ROW   = 9'b000010000,
    PH_CHLEN = 9'b000100000,
    PH_VAL   = 9'b001000000,
    PH_REP   = 9'b010000000,
    PH_IDLE  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [WordW-1:0] start_column;
    logic [WordW-1:0] run_length;
    logic [WordW-1:0] fill_value;
    logic [AddrW-1:0] flat_address;
    logic             row_overflow;
    logic             format_error;
    logic             last_run;
  } run_t;

endpackage

`default_nettype wire

/* rtl/trd_if.sv */
// trd_in_if / trd_out_if: valid-ready channels of the run decoder
// trd_out_if payload widths come from trd_pkg
`default_nettype none

interface trd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       string_start;

  modport source (output valid, output data_byte, output string_start, input ready);
  modport sink   (input valid, input data_byte, input string_start, output ready);
endinterface

interface trd_out_if;
  logic                           valid;
  logic                           ready;
  logic [trd_pkg::ChanW-1:0]      channel;
  logic [trd_pkg::WordW-1:0]      start_column;
  logic [trd_pkg::WordW-1:0]      run_length;
  logic [trd_pkg::WordW-1:0]      fill_value;
  logic [trd_pkg::AddrW-1:0]      flat_address;
  logic                           row_overflow;
  logic                           format_error;
  logic                           last_run;

  modport source (output valid, output channel, output start_column, output run_length,
                  output fill_value, output flat_address, output row_overflow,
                  output format_error, output last_run, input ready);
  modport sink   (input valid, input channel, input start_column, input run_length,
                  input fill_value, input flat_address, input row_overflow,
                  input format_error, input last_run, output ready);
endinterface

`default_nettype wire

/* rtl/timing_string_run_decoder.sv */
// timing_string_run_decoder: byte-serial parser of sparse timing strings into fill runs
// depends on trd_pkg and on the channel interfaces in trd_if.sv
//
//   channel  | dir | payload                                  | request
//   in_chan  | in  | data_byte, string_start                  | one string byte
//   out_chan | out | channel, start_column, run_length,       | one fill run or
//            |     | fill_value, flat_address, flags          | one error result
//
// one byte per cycle while in_chan.ready is high; the parse state updates in the cycle the byte is taken
// a result is registered into the main output entry when it is free, else into the skid entry
// a two-entry output register (main plus skid) keeps input flowing while a result stalls
// in_chan.ready drops only when both output entries are full
// after reset the first byte is header byte 0 even without string_start
`default_nettype none

module timing_string_run_decoder (
  input  wire logic     clk,
  input  wire logic     rst_n,
  trd_in_if.sink        in_chan,
  trd_out_if.source     out_chan
);

  trd_pkg::phase_t                 phase_r, phase_nxt;
  logic [trd_pkg::IdxW-1:0]        byte_idx_r, byte_idx_nxt;
  logic [trd_pkg::ChanW-1:0]       chan_total_r, chan_total_nxt;
  logic [trd_pkg::ChanW-1:0]       chan_idx_r, chan_idx_nxt;
  logic [2:0]                      val_size_r, val_size_nxt;
  logic [trd_pkg::WordW-1:0]       row_len_r, row_len_nxt;
  logic [trd_pkg::WordW-1:0]       bytes_left_r, bytes_left_nxt;
  logic [trd_pkg::ColW-1:0]        col_r, col_nxt;
  logic [trd_pkg::AddrW-1:0]       row_base_r, row_base_nxt;
  logic [trd_pkg::WordW-1:0]       val_sh_r, val_sh_nxt;
  logic [trd_pkg::WordW-1:0]       rep_sh_r, rep_sh_nxt;

  logic          res_push;
  trd_pkg::run_t res;

  logic          out_valid_r, skid_valid_r;
  trd_pkg::run_t out_data_r, skid_data_r;

  logic in_acc, out_pop;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_pop = out_valid_r && out_chan.ready;
  assign in_chan.ready = !skid_valid_r;

  always_comb begin
    trd_pkg::phase_t           ph;
    logic [trd_pkg::IdxW-1:0]  bi;
    logic [trd_pkg::ChanW-1:0] ct, ci, ci_inc;
    logic [2:0]                vs;
    logic [trd_pkg::WordW-1:0] rl, cbl, cbl_dec, vsh, rsh, shifted, col_sat;
    logic [trd_pkg::ColW-1:0]  col;
    logic [trd_pkg::AddrW-1:0] rb, rb_inc;
    logic [33:0]               end_sum;
    logic [4:0]                sh;
    logic                      vs_ok;

    ph  = phase_r;
    bi  = byte_idx_r;
    ct  = chan_total_r;
    ci  = chan_idx_r;
    vs  = val_size_r;
    rl  = row_len_r;
    cbl = bytes_left_r;
    col = col_r;
    rb  = row_base_r;
    vsh = val_sh_r;
    rsh = rep_sh_r;
    if (in_chan.string_start) begin
      ph  = trd_pkg::PH_TOTAL;
      bi  = '0;
      ct  = '0;
      ci  = '0;
      vs  = '0;
      rl  = '0;
      cbl = '0;
      col = '0;
      rb  = '0;
      vsh = '0;
      rsh = '0;
    end

    sh      = {bi[1:0], 3'b000};
    shifted = {24'd0, in_chan.data_byte} << sh;
    cbl_dec = (cbl != '0) ? cbl - 32'd1 : cbl;
    ci_inc  = ci + 8'd1;
    rb_inc  = rb + {8'd0, rl};
    col_sat = col[32] ? '1 : col[31:0];
    end_sum = {1'b0, col} + {2'b00, rsh | shifted};
    vs_ok   = (in_chan.data_byte == trd_pkg::ValSize1) ||
              (in_chan.data_byte == trd_pkg::ValSize2) ||
              (in_chan.data_byte == trd_pkg::ValSize4);

    phase_nxt      = ph;
    byte_idx_nxt   = bi;
    chan_total_nxt = ct;
    chan_idx_nxt   = ci;
    val_size_nxt   = vs;
    row_len_nxt    = rl;
    bytes_left_nxt = cbl;
    col_nxt        = col;
    row_base_nxt   = rb;
    val_sh_nxt     = vsh;
    rep_sh_nxt     = rsh;

    res_push          = 1'b0;
    res.channel       = ci;
    res.start_column  = col_sat;
    res.run_length    = '0;
    res.fill_value    = '0;
    res.flat_address  = rb + {8'd0, col_sat};
    res.row_overflow  = 1'b0;
    res.format_error  = 1'b0;
    res.last_run      = 1'b0;

    unique case (ph)
      trd_pkg::PH_TOTAL: begin
        if (bi >= trd_pkg::TotalLastIdx) begin
          byte_idx_nxt = '0;
          phase_nxt    = trd_pkg::PH_NCHAN;
        end else begin
          byte_idx_nxt = bi + 3'd1;
        end
      end
      trd_pkg::PH_NCHAN: begin
        chan_total_nxt = in_chan.data_byte;
        phase_nxt      = trd_pkg::PH_VSIZE;
      end
      trd_pkg::PH_VSIZE: begin
        val_size_nxt = vs_ok ? in_chan.data_byte[2:0] : 3'd0;
        phase_nxt    = trd_pkg::PH_RSIZE;
      end
      trd_pkg::PH_RSIZE: begin
        if (vs == 3'd0 || in_chan.data_byte != trd_pkg::RepSize4) begin
          // unsupported sizes: one error result with all other fields zero, then discard
          phase_nxt        = trd_pkg::PH_IDLE;
          col_nxt          = '0;
          row_base_nxt     = '0;
          res_push         = 1'b1;
          res.channel      = '0;
          res.start_column = '0;
          res.flat_address = '0;
          res.format_error = 1'b1;
        end else begin
          row_len_nxt  = '0;
          byte_idx_nxt = '0;
          phase_nxt    = trd_pkg::PH_ROW;
        end
      end
      trd_pkg::PH_ROW: begin
        row_len_nxt = rl | shifted;
        if (bi >= trd_pkg::WordLastIdx) begin
          byte_idx_nxt   = '0;
          bytes_left_nxt = '0;
          phase_nxt      = (ct == '0) ? trd_pkg::PH_IDLE : trd_pkg::PH_CHLEN;
        end else begin
          byte_idx_nxt = bi + 3'd1;
        end
      end
      trd_pkg::PH_CHLEN: begin
        bytes_left_nxt = cbl | shifted;
        if (bi < trd_pkg::WordLastIdx) begin
          byte_idx_nxt = bi + 3'd1;
        end else begin
          byte_idx_nxt = '0;
          if ((cbl | shifted) == '0) begin
            // empty channel: close it, final one reports an empty run
            chan_idx_nxt   = ci_inc;
            row_base_nxt   = rb_inc;
            col_nxt        = '0;
            bytes_left_nxt = '0;
            if (ci_inc == ct) begin
              phase_nxt        = trd_pkg::PH_IDLE;
              res_push         = 1'b1;
              res.start_column = '0;
              res.flat_address = rb;
              res.last_run     = 1'b1;
            end else begin
              phase_nxt = trd_pkg::PH_CHLEN;
            end
          end else begin
            val_sh_nxt = '0;
            phase_nxt  = trd_pkg::PH_VAL;
          end
        end
      end
      trd_pkg::PH_VAL: begin
        bytes_left_nxt = cbl_dec;
        val_sh_nxt     = vsh | shifted;
        if ({1'b0, bi} + 4'd1 >= {1'b0, vs}) begin
          byte_idx_nxt = '0;
          rep_sh_nxt   = '0;
          phase_nxt    = trd_pkg::PH_REP;
        end else begin
          byte_idx_nxt = bi + 3'd1;
        end
      end
      trd_pkg::PH_REP: begin
        bytes_left_nxt = cbl_dec;
        rep_sh_nxt     = rsh | shifted;
        if (bi < trd_pkg::WordLastIdx) begin
          byte_idx_nxt = bi + 3'd1;
        end else begin
          byte_idx_nxt     = '0;
          res_push         = 1'b1;
          res.run_length   = rsh | shifted;
          res.fill_value   = vsh;
          res.row_overflow = end_sum > {2'b00, rl};
          col_nxt          = end_sum[33] ? '1 : end_sum[32:0];
          if (cbl_dec == '0) begin
            chan_idx_nxt   = ci_inc;
            row_base_nxt   = rb_inc;
            col_nxt        = '0;
            bytes_left_nxt = '0;
            if (ci_inc == ct) begin
              phase_nxt    = trd_pkg::PH_IDLE;
              res.last_run = 1'b1;
            end else begin
              phase_nxt = trd_pkg::PH_CHLEN;
            end
          end else begin
            val_sh_nxt = '0;
            phase_nxt  = trd_pkg::PH_VAL;
          end
        end
      end
      trd_pkg::PH_IDLE: begin
        phase_nxt = trd_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = trd_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= trd_pkg::PH_TOTAL;
      byte_idx_r   <= '0;
      chan_total_r <= '0;
      chan_idx_r   <= '0;
      val_size_r   <= '0;
      row_len_r    <= '0;
      bytes_left_r <= '0;
      col_r        <= '0;
      row_base_r   <= '0;
      val_sh_r     <= '0;
      rep_sh_r     <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      byte_idx_r   <= byte_idx_nxt;
      chan_total_r <= chan_total_nxt;
      chan_idx_r   <= chan_idx_nxt;
      val_size_r   <= val_size_nxt;
      row_len_r    <= row_len_nxt;
      bytes_left_r <= bytes_left_nxt;
      col_r        <= col_nxt;
      row_base_r   <= row_base_nxt;
      val_sh_r     <= val_sh_nxt;
      rep_sh_r     <= rep_sh_nxt;
    end
  end

  // output register with skid entry
  logic new_res;
  assign new_res = in_acc && res_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_pop) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= new_res;
        end else begin
          out_valid_r  <= new_res;
          skid_valid_r <= 1'b0;
        end
      end else if (new_res) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        if (new_res) begin
          skid_data_r <= res;
        end
      end else if (new_res) begin
        out_data_r <= res;
      end
    end else if (new_res) begin
      skid_data_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.channel      = out_data_r.channel;
  assign out_chan.start_column = out_data_r.start_column;
  assign out_chan.run_length   = out_data_r.run_length;
  assign out_chan.fill_value   = out_data_r.fill_value;
  assign out_chan.flat_address = out_data_r.flat_address;
  assign out_chan.row_overflow = out_data_r.row_overflow;
  assign out_chan.format_error = out_data_r.format_error;
  assign out_chan.last_run     = out_data_r.last_run;

  // skid entry is only ever filled behind a full main entry
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without main entry");

  // a held skid entry keeps its payload while the main entry stalls
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_pop) |=> (skid_valid_r && $stable(skid_data_r)))
    else $error("skid payload changed while stalled");

  // the error result carries nothing but the error flag
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.format_error) |->
      (out_data_r.run_length == '0 && !out_data_r.last_run && !out_data_r.row_overflow
       && out_data_r.flat_address == '0))
    else $error("format error result with nonzero fields");

  // the run closing the final channel leaves the parser discarding bytes
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (new_res && res.last_run) |=> (phase_r == trd_pkg::PH_IDLE))
    else $error("parser not idle after final run");

endmodule

`default_nettype wire

/* dv/timing_string_run_decoder_test.sv */
// timing_string_run_decoder_test: byte-level test of the timing string run decoder
// streams random and hand-built strings, predicts every fill run, checks field by field
// depends on trd_pkg, trd_in_if / trd_out_if and timing_string_run_decoder
module timing_string_run_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import trd_pkg::*;

  localparam int unsigned NumBytes    = 1950;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 16;
  localparam logic [ColW:0] ColSat    = {1'b0, {ColW{1'b1}}};
  localparam logic [ColW-1:0] ColMax32 = {1'b0, {WordW{1'b1}}};

  typedef struct {
    logic [7:0] data;
    logic       restart;
  } str_byte_t;

  logic clk;
  logic rst_n;

  trd_in_if  in_if();
  trd_out_if out_if();

  timing_string_run_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  str_byte_t   string_bytes[$];
  run_t        expected_runs[$];
  int unsigned bytes_taken;
  int unsigned runs_seen;
  int unsigned errors_seen;
  int unsigned overflows_seen;
  int unsigned finals_seen;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned idle_left;
  int unsigned stall_left;
  bit          src_calm;
  bit          sink_calm;

  // parser state as the decoder holds it
  phase_t           phase;
  logic [IdxW-1:0]  idx;
  logic [7:0]       chan_total;
  logic [7:0]       chan_idx;
  logic [2:0]       val_size;
  logic [2:0]       rep_size;
  logic [31:0]      row_len;
  logic [31:0]      bytes_left;
  logic [31:0]      val_acc;
  logic [31:0]      rep_acc;
  logic [ColW-1:0]  col_pos;
  logic [AddrW-1:0] row_base;

  function automatic void clear_parse();
    phase      = PH_TOTAL;
    idx        = '0;
    chan_total = '0;
    chan_idx   = '0;
    val_size   = '0;
    rep_size   = '0;
    row_len    = '0;
    bytes_left = '0;
    val_acc    = '0;
    rep_acc    = '0;
    col_pos    = '0;
    row_base   = '0;
  endfunction

  function automatic run_t make_run(input logic [7:0] ch, input logic [31:0] len, val,
                                    input logic ovf, err, last,
                                    input logic [AddrW-1:0] base_at);
    run_t        r;
    logic [31:0] col;
    col = (col_pos > ColMax32) ? '1 : col_pos[31:0];
    r.channel      = ch;
    r.start_column = col;
    r.run_length   = len;
    r.fill_value   = val;
    r.flat_address = base_at + AddrW'(col);
    r.row_overflow = ovf;
    r.format_error = err;
    r.last_run     = last;
    return r;
  endfunction

  // returns 1 when the channel just closed was the final one
  function automatic bit close_channel();
    chan_idx   = chan_idx + 8'd1;
    row_base   = row_base + AddrW'(row_len);
    col_pos    = '0;
    bytes_left = '0;
    idx        = '0;
    if (chan_idx == chan_total) begin
      phase = PH_IDLE;
      return 1'b1;
    end
    phase = PH_CHLEN;
    return 1'b0;
  endfunction

  task automatic parse_string_byte(input logic [7:0] b, input logic restart);
    logic [4:0]       sh;
    logic [7:0]       ch;
    logic [AddrW-1:0] old_base;
    logic [ColW:0]    run_end;
    run_t             r;
    sh = {idx[1:0], 3'b000};
    if (restart) clear_parse();
    ch = chan_idx;
    case (phase)
      PH_TOTAL: begin
        if (idx >= TotalLastIdx) begin
          idx   = '0;
          phase = PH_NCHAN;
        end else begin
          idx = idx + 1'b1;
        end
      end
      PH_NCHAN: begin
        chan_total = b;
        phase      = PH_VSIZE;
      end
      PH_VSIZE: begin
        val_size = (b == ValSize1 || b == ValSize2 || b == ValSize4) ? b[2:0] : 3'd0;
        phase    = PH_RSIZE;
      end
      PH_RSIZE: begin
        rep_size = (b == RepSize4) ? RepSize4[2:0] : 3'd0;
        if (val_size == 0 || rep_size == 0) begin
          phase    = PH_IDLE;
          col_pos  = '0;
          row_base = '0;
          expected_runs.push_back(make_run('0, '0, '0, 1'b0, 1'b1, 1'b0, '0));
        end else begin
          row_len = '0;
          idx     = '0;
          phase   = PH_ROW;
        end
      end
      PH_ROW: begin
        row_len |= 32'(b) << sh;
        if (idx >= WordLastIdx) begin
          idx        = '0;
          bytes_left = '0;
          phase      = (chan_total == 0) ? PH_IDLE : PH_CHLEN;
        end else begin
          idx = idx + 1'b1;
        end
      end
      PH_CHLEN: begin
        bytes_left |= 32'(b) << sh;
        if (idx < WordLastIdx) begin
          idx = idx + 1'b1;
        end else begin
          idx = '0;
          if (bytes_left == 0) begin
            // empty channel: only the final one reports, as a zero-length run
            old_base = row_base;
            if (close_channel())
              expected_runs.push_back(make_run(ch, '0, '0, 1'b0, 1'b0, 1'b1, old_base));
          end else begin
            val_acc = '0;
            phase   = PH_VAL;
          end
        end
      end
      PH_VAL: begin
        if (bytes_left != 0) bytes_left = bytes_left - 1;
        val_acc |= 32'(b) << sh;
        if (32'(idx) + 1 >= 32'(val_size)) begin
          idx     = '0;
          rep_acc = '0;
          phase   = PH_REP;
        end else begin
          idx = idx + 1'b1;
        end
      end
      PH_REP: begin
        if (bytes_left != 0) bytes_left = bytes_left - 1;
        rep_acc |= 32'(b) << sh;
        if (idx < WordLastIdx) begin
          idx = idx + 1'b1;
        end else begin
          idx     = '0;
          run_end = (ColW+1)'(col_pos) + (ColW+1)'(rep_acc);
          r = make_run(ch, rep_acc, val_acc, run_end > (ColW+1)'(row_len), 1'b0, 1'b0,
                       row_base);
          col_pos = (run_end > ColSat) ? '1 : run_end[ColW-1:0];
          if (bytes_left == 0) begin
            r.last_run = close_channel();
          end else begin
            val_acc = '0;
            phase   = PH_VAL;
          end
          expected_runs.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_byte(input logic [7:0] data, input logic restart);
    str_byte_t s;
    s.data    = data;
    s.restart = restart;
    string_bytes.push_back(s);
  endfunction

  function automatic void put_word(input logic [31:0] w, input int unsigned nbytes);
    for (int unsigned i = 0; i < nbytes; i++) put_byte(w[8*i +: 8], 1'b0);
  endfunction

  // one timing string, mostly well formed; some bad formats, cut strings and noise
  function automatic void add_timing_string();
    int unsigned mark, n_ch, vs, rs, psize, n_pairs, k, keep;
    logic [31:0] row, clen, rep;
    bit          runaway;
    mark = string_bytes.size();
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 24))
        put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    put_byte(8'($urandom_range(0, 255)), 1'b1);
    repeat (7) put_byte(8'($urandom_range(0, 255)), 1'b0);
    k = $urandom_range(0, 99);
    n_ch = (k < 4) ? 0 : (k < 10) ? $urandom_range(5, 40) : $urandom_range(1, 4);
    put_byte(8'(n_ch), 1'b0);
    case ($urandom_range(0, 2))
      0:       vs = ValSize1;
      1:       vs = ValSize2;
      default: vs = ValSize4;
    endcase
    rs = RepSize4;
    if ($urandom_range(0, 99) < 10) begin
      if ($urandom_range(0, 1)) begin
        do vs = $urandom_range(0, 255);
        while (vs == ValSize1 || vs == ValSize2 || vs == ValSize4);
      end else begin
        do rs = $urandom_range(0, 255); while (rs == RepSize4);
      end
    end
    put_byte(8'(vs), 1'b0);
    put_byte(8'(rs), 1'b0);
    if ((vs == ValSize1 || vs == ValSize2 || vs == ValSize4) && rs == RepSize4) begin
      k = $urandom_range(0, 99);
      row = (k < 10) ? 32'd0 : (k < 20) ? '1 : (k < 30) ? $urandom : $urandom_range(1, 64);
      put_word(row, 4);
      psize   = vs + 4;
      runaway = 1'b0;
      for (int unsigned c = 0; c < n_ch && !runaway; c++) begin
        n_pairs = (n_ch > 4 && $urandom_range(0, 4) != 0) ? 0 : $urandom_range(0, 4);
        clen    = n_pairs * psize;
        k       = $urandom_range(0, 99);
        if (n_pairs > 0 && k < 20) begin
          clen = clen - $urandom_range(0, psize - 1);
        end else if (n_pairs > 0 && k < 23) begin
          // channel never ends inside this string
          clen    = $urandom_range(0, 1) ? '1 : $urandom;
          runaway = 1'b1;
        end
        put_word(clen, 4);
        repeat (n_pairs) begin
          put_word($urandom, vs);
          k = $urandom_range(0, 99);
          rep = (k < 55) ? $urandom_range(0, 16) : (k < 75) ? $urandom_range(0, 80) :
                (k < 88) ? '1 : (k < 94) ? $urandom : 32'd0;
          put_word(rep, 4);
        end
      end
    end
    if ($urandom_range(0, 99) < 6) begin
      keep = mark + $urandom_range(1, string_bytes.size() - mark);
      while (string_bytes.size() > keep) void'(string_bytes.pop_back());
    end
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  function automatic void check_field(input string name, input logic [AddrW-1:0] want, got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    str_byte_t nxt;
    if (!rst_n) begin
      in_if.valid        <= 1'b0;
      in_if.data_byte    <= '0;
      in_if.string_start <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_string_byte(in_if.data_byte, in_if.string_start);
        bytes_taken++;
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (idle_left > 0) begin
          idle_left--;
          in_if.valid <= 1'b0;
        end else if (string_bytes.size() > 0) begin
          nxt = string_bytes.pop_front();
          in_if.valid        <= 1'b1;
          in_if.data_byte    <= nxt.data;
          in_if.string_start <= nxt.restart;
          idle_left = pick_gap(src_calm);
          if ($urandom_range(0, 199) == 0) src_calm = !src_calm;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready stalls
  always @(posedge clk) begin
    run_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected run on channel %0d", out_if.channel);
          fail_count++;
        end else begin
          want = expected_runs.pop_front();
          check_field("channel", AddrW'(want.channel), AddrW'(out_if.channel));
          check_field("start_column", AddrW'(want.start_column),
                      AddrW'(out_if.start_column));
          check_field("run_length", AddrW'(want.run_length), AddrW'(out_if.run_length));
          check_field("fill_value", AddrW'(want.fill_value), AddrW'(out_if.fill_value));
          check_field("flat_address", want.flat_address, out_if.flat_address);
          check_field("row_overflow", AddrW'(want.row_overflow),
                      AddrW'(out_if.row_overflow));
          check_field("format_error", AddrW'(want.format_error),
                      AddrW'(out_if.format_error));
          check_field("last_run", AddrW'(want.last_run), AddrW'(out_if.last_run));
          runs_seen++;
          if (want.format_error) errors_seen++;
          if (want.row_overflow) overflows_seen++;
          if (want.last_run) finals_seen++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap(sink_calm);
        if ($urandom_range(0, 199) == 0) sink_calm = !sink_calm;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d runs still expected", cycle_count,
               expected_runs.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned total;
    rst_n = 1'b0;
    clear_parse();

    // first string right after reset, no restart flag, bad value size
    put_byte(8'h00, 1'b0);
    repeat (7) put_byte(8'hFF, 1'b0);
    put_byte(8'd2, 1'b0);
    put_byte(8'd3, 1'b0);
    put_byte(RepSize4, 1'b0);
    put_byte(8'hA5, 1'b0);
    // one channel with no pairs, widest row
    put_byte(8'h00, 1'b1);
    repeat (7) put_byte(8'h00, 1'b0);
    put_byte(8'd1, 1'b0);
    put_byte(ValSize1, 1'b0);
    put_byte(RepSize4, 1'b0);
    put_word('1, 4);
    put_word('0, 4);

    while (string_bytes.size() < NumBytes) add_timing_string();
    total = string_bytes.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total) @(posedge clk);
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d string bytes sent, %0d runs checked", bytes_taken, runs_seen);
    $display("%0d overflowing runs, %0d format errors, %0d closing runs", overflows_seen,
             errors_seen, finals_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
